[hw/rtl/u8sv_pkg.sv]
`timescale 1ns / 1ps
// Package for the UTF-8 string validator: verdict codes and decode constants.
// Used by utf8_string_validator and by its port checker u8sv_checker.
// No dependencies.

package u8sv_pkg;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_EMPTY     = 4'd1,
        ERR_CONTROL   = 4'd2,
        ERR_LEAD      = 4'd3,
        ERR_CONT      = 4'd4,
        ERR_OVERLONG  = 4'd5,
        ERR_SURROGATE = 4'd6,
        ERR_ABOVE     = 4'd7,
        ERR_UNTERM    = 4'd8
    } err_t;

    localparam int unsigned CP_W = 21;

    localparam logic [7:0] CTRL_LIMIT  = 8'h20;
    localparam logic [7:0] DEL_CHAR    = 8'h7f;
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD2_LO    = 8'hc2;
    localparam logic [7:0] LEAD2_HI    = 8'hdf;
    localparam logic [7:0] LEAD3_LO    = 8'he0;
    localparam logic [7:0] LEAD3_HI    = 8'hef;
    localparam logic [7:0] LEAD4_LO    = 8'hf0;
    localparam logic [7:0] LEAD4_HI    = 8'hf4;

    localparam logic [CP_W-1:0] CP_MIN2   = 21'h00080;
    localparam logic [CP_W-1:0] CP_MIN3   = 21'h00800;
    localparam logic [CP_W-1:0] CP_MIN4   = 21'h10000;
    localparam logic [CP_W-1:0] CP_MAX    = 21'h10ffff;
    localparam logic [CP_W-1:0] SURR_LO   = 21'h0d800;
    localparam logic [CP_W-1:0] SURR_HI   = 21'h0dfff;

    // Smallest code point that each sequence length may legally encode.
    function automatic logic [CP_W-1:0] class_min(input logic [1:0] cls);
        logic [CP_W-1:0] m;
        unique case (cls)
            2'd0:    m = CP_MIN2;
            2'd1:    m = CP_MIN3;
            default: m = CP_MIN4;
        endcase
        return m;
    endfunction

endpackage

[hw/rtl/utf8_string_validator.sv]
`timescale 1ns / 1ps
// Streaming UTF-8 string validator, one byte per transaction.
// Depends on u8sv_pkg for verdict codes and decode constants.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one string byte per
//   transaction. capacity and need_text are sampled only with the first
//   byte of a string and ignored on later bytes. A string ends on a NUL
//   byte or on the byte at index capacity-1.
//   The output channel (out_valid/out_ready) carries one verdict per
//   string: valid_res, error (first error seen) and length (index of the
//   ending byte).
//   Throughput is one byte per clock. A byte is decoded in the input
//   register against the per-string state; a byte that ends a string
//   then loads its verdict from there into the output register, which
//   drives out_valid.
//   If the receiver stalls, bytes that do not end a string keep flowing.
//   A byte that ends a string waits in the input register while the
//   output register is still full, and in_ready stays low until it moves.
//   Reset clears both registers and all string state; the next byte
//   accepted starts a new string.

module utf8_string_validator (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              byte_req,
    input  logic [15:0]             capacity,
    input  logic                    need_text,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    valid_res,
    output u8sv_pkg::err_t          error,
    output logic [15:0]             length
);
    import u8sv_pkg::*;

    // Input register.
    logic              in_valid_reg;
    logic [7:0]        byte_reg;
    logic [15:0]       cap_in_reg;
    logic              nt_in_reg;

    // Per-string state.
    logic [15:0]       byte_index_reg, byte_index_next;
    logic [1:0]        pending_reg, pending_next;
    logic [CP_W-1:0]   accum_reg, accum_next;
    logic [1:0]        min_class_reg, min_class_next;
    err_t              first_err_reg, first_err_next;
    logic [15:0]       held_cap_reg, held_cap_next;
    logic              held_nt_reg, held_nt_next;

    // Result register.
    logic              out_valid_reg;
    logic              valid_res_reg;
    err_t              error_reg;
    logic [15:0]       length_reg;

    logic              first;
    logic [15:0]       cur_cap;
    logic              cur_nt;
    logic [1:0]        cur_pend;
    logic [CP_W-1:0]   cur_acc;
    logic [1:0]        cur_cls;
    err_t              cur_err;
    logic [16:0]       idx_p1;
    logic [CP_W-1:0]   cont_cp;
    logic [1:0]        lead_need;
    logic [CP_W-1:0]   lead_cp;
    err_t              dec_err;
    logic [1:0]        dec_pend;
    logic [CP_W-1:0]   dec_acc;
    logic [1:0]        dec_cls;
    logic              last;
    logic              done;
    logic              advance;
    logic              fire;

    // The first byte of a string sees freshly cleared state.
    assign first    = (byte_index_reg == 16'd0);
    assign cur_cap  = first ? cap_in_reg : held_cap_reg;
    assign cur_nt   = first ? nt_in_reg : held_nt_reg;
    assign cur_pend = first ? 2'd0 : pending_reg;
    assign cur_acc  = first ? '0 : accum_reg;
    assign cur_cls  = first ? 2'd0 : min_class_reg;
    assign cur_err  = first ? ERR_NONE : first_err_reg;

    assign idx_p1  = {1'b0, byte_index_reg} + 17'd1;
    assign cont_cp = {cur_acc[CP_W-7:0], byte_reg[5:0]};

    always_comb
    begin
        lead_need = 2'd0;
        lead_cp   = '0;
        if (byte_reg >= LEAD2_LO && byte_reg <= LEAD2_HI)
        begin
            lead_need = 2'd1;
            lead_cp   = {16'd0, byte_reg[4:0]};
        end
        else if (byte_reg >= LEAD3_LO && byte_reg <= LEAD3_HI)
        begin
            lead_need = 2'd2;
            lead_cp   = {17'd0, byte_reg[3:0]};
        end
        else if (byte_reg >= LEAD4_LO && byte_reg <= LEAD4_HI)
        begin
            lead_need = 2'd3;
            lead_cp   = {18'd0, byte_reg[2:0]};
        end
    end

    always_comb
    begin
        dec_err  = ERR_NONE;
        dec_pend = cur_pend;
        dec_acc  = cur_acc;
        dec_cls  = cur_cls;
        if (cur_pend != 2'd0)
        begin
            if (byte_reg[7:6] != 2'b10)
            begin
                dec_err = ERR_CONT;
            end
            else
            begin
                dec_acc  = cont_cp;
                dec_pend = cur_pend - 2'd1;
                if (dec_pend == 2'd0)
                begin
                    // Overlong takes precedence over range and surrogate checks.
                    priority if (cont_cp < class_min(cur_cls))
                        dec_err = ERR_OVERLONG;
                    else if (cont_cp > CP_MAX)
                        dec_err = ERR_ABOVE;
                    else if (cont_cp >= SURR_LO && cont_cp <= SURR_HI)
                        dec_err = ERR_SURROGATE;
                    else
                        dec_err = ERR_NONE;
                end
            end
        end
        else if (byte_reg == 8'd0)
        begin
            dec_err = ERR_NONE;
        end
        else if (byte_reg < CTRL_LIMIT || byte_reg == DEL_CHAR)
        begin
            dec_err = ERR_CONTROL;
        end
        else if (byte_reg < ASCII_LIMIT)
        begin
            dec_err = ERR_NONE;
        end
        else if (lead_need != 2'd0)
        begin
            // The continuation bytes must not reach the slot kept for the NUL.
            if ((idx_p1 + {15'd0, lead_need}) >= {1'b0, cur_cap})
            begin
                dec_err = ERR_CONT;
            end
            else
            begin
                dec_pend = lead_need;
                dec_acc  = lead_cp;
                dec_cls  = lead_need - 2'd1;
            end
        end
        else
        begin
            dec_err = ERR_LEAD;
        end
    end

    always_comb
    begin
        first_err_next = cur_err;
        pending_next   = cur_pend;
        accum_next     = cur_acc;
        min_class_next = cur_cls;
        held_cap_next  = cur_cap;
        held_nt_next   = cur_nt;
        if (cur_err == ERR_NONE)
        begin
            if (first && byte_reg == 8'd0 && cur_nt)
            begin
                first_err_next = ERR_EMPTY;
            end
            else
            begin
                pending_next   = dec_pend;
                accum_next     = dec_acc;
                min_class_next = dec_cls;
                if (dec_err != ERR_NONE)
                begin
                    first_err_next = dec_err;
                    pending_next   = 2'd0;
                end
            end
        end
        last = (idx_p1 >= {1'b0, cur_cap});
        if (last && byte_reg != 8'd0 && first_err_next == ERR_NONE)
            first_err_next = ERR_UNTERM;
        done = (byte_reg == 8'd0) || last;
        byte_index_next = idx_p1[15:0];
    end

    assign advance  = !done || !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            byte_index_reg <= '0;
            pending_reg    <= '0;
            accum_reg      <= '0;
            min_class_reg  <= '0;
            first_err_reg  <= ERR_NONE;
            held_cap_reg   <= '0;
            held_nt_reg    <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (fire && done)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (fire)
            begin
                held_cap_reg <= held_cap_next;
                held_nt_reg  <= held_nt_next;
                if (done)
                begin
                    byte_index_reg <= '0;
                    pending_reg    <= '0;
                    accum_reg      <= '0;
                    min_class_reg  <= '0;
                    first_err_reg  <= ERR_NONE;
                end
                else
                begin
                    byte_index_reg <= byte_index_next;
                    pending_reg    <= pending_next;
                    accum_reg      <= accum_next;
                    min_class_reg  <= min_class_next;
                    first_err_reg  <= first_err_next;
                end
            end
        end
    end

    // Payload registers carry no reset; their valid flags guard them.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg   <= byte_req;
            cap_in_reg <= capacity;
            nt_in_reg  <= need_text;
        end
        if (fire && done)
        begin
            valid_res_reg <= (first_err_next == ERR_NONE);
            error_reg     <= first_err_next;
            length_reg    <= byte_index_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign valid_res = valid_res_reg;
    assign error     = error_reg;
    assign length    = length_reg;

endmodule

[hw/rtl/u8sv_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for utf8_string_validator, attached by bind.
// Depends on u8sv_pkg for the verdict codes.

module u8sv_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic [7:0]              byte_req,
    input logic [15:0]             capacity,
    input logic                    need_text,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic                    valid_res,
    input u8sv_pkg::err_t          error,
    input logic [15:0]             length
);
    import u8sv_pkg::*;

    // A waiting input transaction keeps its payload until it is accepted.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(byte_req)
            && $stable(capacity) && $stable(need_text))
        else $error("input changed while stalled");

    // A stalled verdict holds until the transaction completes.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(valid_res)
            && $stable(error) && $stable(length))
        else $error("verdict changed while stalled");

    // The pass flag agrees with the error code.
    a_valid_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (valid_res == (error == ERR_NONE)))
        else $error("valid_res disagrees with error");

    // Only defined verdict codes are produced.
    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (error <= ERR_UNTERM))
        else $error("undefined error code");

    // An empty-string verdict always comes from the first byte.
    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error == ERR_EMPTY |-> length == 16'd0)
        else $error("empty verdict with nonzero length");

endmodule

bind utf8_string_validator u8sv_checker u_u8sv_checker (.*);
